[rtl/fifo_from_two_stacks_unit_macros.svh]
// Assertion macros for the two-stack queue.
`ifndef FIFO_FROM_TWO_STACKS_UNIT_MACROS_SVH
`define FIFO_FROM_TWO_STACKS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle check, off while reset is high.
`define FTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define FTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FTS_ASSERT(lbl, clk, rst, prop, msg)
`define FTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/fts_pkg.sv]
package fts_pkg;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_XFER,
      FS_POP
   } fsm_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      status_type         status;
   } rsp_type;

endpackage

[rtl/fts_ram.sv]
module fts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fifo_from_two_stacks_unit.sv]
// First-in first-out queue of signed 32-bit values built on two stacks.
// Input channel (req_*): one beat is a command, enqueue or dequeue, plus the
// value to enqueue. Result channel (rsp_*): exactly one beat per command,
// carrying the dequeued value (zero otherwise) and a status: ok, empty on a
// dequeue of an empty queue, or full on an enqueue while the inbound stack
// holds STACK_DEPTH entries. Enqueue, full enqueue and empty dequeue load
// the result register when accepted. A dequeue with entries on the
// outbound stack reads the outbound top, then loads it as the result. With
// an empty outbound stack, a single inbound entry is read directly; with
// more, a transfer moves all but the bottom inbound entry to the outbound
// stack and returns the bottom entry. One command is in flight at a time;
// both stack memories have a registered read, and a transfer moves one
// entry per cycle through the inbound read port. Each entry moves at most
// once.
// Results sit in an output register; a new command is taken while the
// previous result is being taken in the same cycle. While the receiver
// stalls, rsp_data holds and req_ready stays low.
// Reset clears both stack counts and the control state; the memories are
// not cleared and no entry is read before it has been written.
`include "fifo_from_two_stacks_unit_macros.svh"

module fifo_from_two_stacks_unit #(
   parameter int STACK_DEPTH = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fts_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output fts_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   fts_pkg::fsm_type state_ff, state_in;

   logic [CW-1:0] icount_ff, icount_in;
   logic [CW-1:0] ocount_ff, ocount_in;
   logic [CW-1:0] icount_dec, ocount_dec;

   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          pop_inb_ff, pop_inb_in;

   logic             rsp_valid_ff, rsp_valid_in;
   fts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          in_wr_en, in_rd_en;
   logic [AW-1:0] in_rd_addr;
   logic [31:0]   in_rd_data;
   logic          out_rd_en;
   logic [AW-1:0] out_rd_addr;
   logic [31:0]   out_rd_data;

   logic slot_free, req_fire, rsp_load;
   logic signed [31:0]  rsp_value;
   fts_pkg::status_type rsp_status;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == fts_pkg::FS_IDLE) && slot_free;
   assign req_fire   = req_valid && req_ready;
   assign icount_dec = icount_ff - ONE_C;
   assign ocount_dec = ocount_ff - ONE_C;

   fts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_inbound (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (icount_ff[AW-1:0]),
      .wr_data (req_data.value_in),
      .rd_en   (in_rd_en),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   // Each transfer write happens in the cycle after its inbound read, from the registered read data.
   fts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_outbound (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (in_rd_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fts_pkg::FS_IDLE: begin
            if (req_fire && req_data.cmd == fts_pkg::CMD_DEQ) begin
               if (ocount_ff != '0) begin
                  state_in = fts_pkg::FS_POP;
               end else if (icount_ff == ONE_C) begin
                  state_in = fts_pkg::FS_POP;
               end else if (icount_ff != '0) begin
                  state_in = fts_pkg::FS_XFER;
               end
            end
         end
         fts_pkg::FS_XFER: begin
            if (icount_ff == ONE_C) begin
               state_in = fts_pkg::FS_POP;
            end
         end
         fts_pkg::FS_POP: begin
            state_in = fts_pkg::FS_IDLE;
         end
         default: begin
            state_in = fts_pkg::FS_IDLE;
         end
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      icount_in   = icount_ff;
      ocount_in   = ocount_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = ocount_ff[AW-1:0];
      pop_inb_in  = pop_inb_ff;
      in_wr_en    = 1'b0;
      in_rd_en    = 1'b0;
      in_rd_addr  = icount_dec[AW-1:0];
      out_rd_en   = 1'b0;
      out_rd_addr = ocount_dec[AW-1:0];
      rsp_load    = 1'b0;
      rsp_value   = '0;
      rsp_status  = fts_pkg::ST_OK;
      case (state_ff)
         fts_pkg::FS_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == fts_pkg::CMD_ENQ) begin
                  rsp_load = 1'b1;
                  if (icount_ff == DEPTH_C) begin
                     rsp_status = fts_pkg::ST_FULL;
                  end else begin
                     in_wr_en  = 1'b1;
                     icount_in = icount_ff + ONE_C;
                  end
               end else if (ocount_ff != '0) begin
                  out_rd_en  = 1'b1;
                  ocount_in  = ocount_dec;
                  pop_inb_in = 1'b0;
               end else if (icount_ff == '0) begin
                  rsp_load   = 1'b1;
                  rsp_status = fts_pkg::ST_EMPTY;
               end else if (icount_ff == ONE_C) begin
                  // single entry: it is the queue head, take it directly
                  in_rd_en   = 1'b1;
                  icount_in  = '0;
                  pop_inb_in = 1'b1;
               end
            end
         end
         fts_pkg::FS_XFER: begin
            in_rd_en  = 1'b1;
            icount_in = icount_dec;
            if (icount_ff == ONE_C) begin
               // bottom inbound entry is the head; return it, skip the move
               pop_inb_in = 1'b1;
            end else begin
               wr_pend_in = 1'b1;
               ocount_in  = ocount_ff + ONE_C;
            end
         end
         fts_pkg::FS_POP: begin
            rsp_load  = 1'b1;
            rsp_value = pop_inb_ff ? in_rd_data : out_rd_data;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in.value_out = rsp_value;
      rsp_data_in.status    = rsp_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fts_pkg::FS_IDLE;
         icount_ff    <= '0;
         ocount_ff    <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         icount_ff    <= icount_in;
         ocount_ff    <= ocount_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      pop_inb_ff <= pop_inb_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FTS_ASSERT(a_count_range, clock, reset, icount_ff <= DEPTH_C && ocount_ff <= DEPTH_C, "stack count beyond depth")
   `FTS_ASSERT(a_xfer_has_entries, clock, reset, state_ff != fts_pkg::FS_XFER || icount_ff != '0, "transfer with empty inbound stack")
   `FTS_ASSERT_NEXT(a_accept_progress, clock, reset, req_fire, rsp_valid_ff || state_ff != fts_pkg::FS_IDLE, "accepted beat neither answered nor in progress")
   `FTS_ASSERT_NEXT(a_pop_result, clock, reset, state_ff == fts_pkg::FS_POP, rsp_valid_ff && state_ff == fts_pkg::FS_IDLE, "pop did not produce a result")

endmodule

[sim/fifo_from_two_stacks_unit_checker.sv]
`timescale 1ns / 100ps

module fifo_from_two_stacks_unit_checker #(
   parameter int STACK_DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  fts_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  fts_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               results_owed
);

   logic signed [31:0] inbound_entries  [STACK_DEPTH];
   logic signed [31:0] outbound_entries [STACK_DEPTH];
   int                 inbound_fill  = 0;
   int                 outbound_fill = 0;
   fts_pkg::rsp_type   owed_results [$];
   int                 fails = 0;
   int                 owed  = 0;

   assign mismatch_count = fails;
   assign results_owed   = owed;

   // Apply one command to the shadow stacks and return the result it should produce.
   function automatic fts_pkg::rsp_type apply_command(fts_pkg::req_type beat);
      fts_pkg::rsp_type r;
      r.value_out = '0;
      r.status    = fts_pkg::ST_OK;
      if (beat.cmd == fts_pkg::CMD_ENQ) begin
         if (inbound_fill >= STACK_DEPTH) begin
            r.status = fts_pkg::ST_FULL;
         end else begin
            inbound_entries[inbound_fill] = beat.value_in;
            inbound_fill++;
         end
      end else begin
         // refill outbound only once it has run dry; order reverses here
         if (outbound_fill == 0) begin
            while (inbound_fill > 0) begin
               inbound_fill--;
               outbound_entries[outbound_fill] = inbound_entries[inbound_fill];
               outbound_fill++;
            end
         end
         if (outbound_fill == 0) begin
            r.status = fts_pkg::ST_EMPTY;
         end else begin
            outbound_fill--;
            r.value_out = outbound_entries[outbound_fill];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      fts_pkg::rsp_type want;
      if (reset) begin
         inbound_fill  = 0;
         outbound_fill = 0;
         owed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               fails++;
               $display("%0t: unexpected result beat, got value_out=%0d status=%0d",
                        $time, rsp_data.value_out, rsp_data.status);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.value_out !== want.value_out) begin
                  fails++;
                  $display("%0t: value_out mismatch, expected %0d, got %0d",
                           $time, want.value_out, rsp_data.value_out);
               end
               if (rsp_data.status !== want.status) begin
                  fails++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
               end
            end
         end
         if (req_valid && req_ready)
            owed_results.push_back(apply_command(req_data));
      end
      owed = owed_results.size();
   end

endmodule

[sim/fifo_from_two_stacks_unit_tb.sv]
`timescale 1ns / 100ps

module fifo_from_two_stacks_unit_tb;

   localparam int DEPTH = 128;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   fts_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   fts_pkg::rsp_type rsp_data;

   int mismatch_count;
   int results_owed;
   int send_idle_pct = 33;
   int take_idle_pct = 74;
   int phase         = 1;
   bit hold_done     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fifo_from_two_stacks_unit #(
      .STACK_DEPTH(DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   fifo_from_two_stacks_unit_checker #(
      .STACK_DEPTH(DEPTH)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .results_owed  (results_owed)
   );

   // Offer one command beat and hold it until the block takes it.
   task automatic send_beat(logic op, logic signed [31:0] operand);
      bit taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data.cmd      <= op;
      req_data.value_in <= operand;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Bursts of enqueues and dequeues, some long enough to fill or drain a stack.
   task automatic run_mixed_traffic(int n_items);
      int   sent;
      int   kind;
      int   run_len;
      logic op;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         op   = fts_pkg::CMD_ENQ;
         case (kind)
            0, 1, 2, 3: run_len = $urandom_range(1, 12);
            4, 5, 6: begin
               op      = fts_pkg::CMD_DEQ;
               run_len = $urandom_range(1, 12);
            end
            7: run_len = $urandom_range(DEPTH / 2, DEPTH + 8);
            8: begin
               op      = fts_pkg::CMD_DEQ;
               run_len = $urandom_range(DEPTH / 2, DEPTH + 8);
            end
            default: run_len = $urandom_range(1, 8);
         endcase
         repeat (run_len) begin
            if (kind == 9)
               op = ($urandom_range(0, 1) == 0) ? fts_pkg::CMD_ENQ : fts_pkg::CMD_DEQ;
            send_beat(op, pick_operand());
            sent++;
         end
      end
   endtask

   // Starting from empty: hit full on inbound twice, the second time with outbound loaded too.
   task automatic fill_and_drain();
      repeat (DEPTH + 1) send_beat(fts_pkg::CMD_ENQ, pick_operand());
      send_beat(fts_pkg::CMD_DEQ, pick_operand());
      repeat (DEPTH + 1) send_beat(fts_pkg::CMD_ENQ, pick_operand());
      repeat (2 * DEPTH + 1) send_beat(fts_pkg::CMD_DEQ, pick_operand());
   endtask

   initial begin : take_side
      int hold_left;
      int phase3_cycles;
      hold_left     = 0;
      phase3_cycles = 0;
      forever begin
         @(posedge clock);
         if (phase == 3 && !hold_done) begin
            phase3_cycles++;
            if (phase3_cycles == 40)
               hold_left = 400;
         end
         if (hold_left > 0) begin
            // hold off long enough for the block to back up its input
            hold_left--;
            if (hold_left == 0)
               hold_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= take_idle_pct);
         end
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(fts_pkg::CMD_DEQ, '1);
      send_beat(fts_pkg::CMD_ENQ, 32'sh7fff_ffff);
      send_beat(fts_pkg::CMD_ENQ, 32'sh8000_0000);
      send_beat(fts_pkg::CMD_ENQ, '0);
      send_beat(fts_pkg::CMD_ENQ, '1);
      send_beat(fts_pkg::CMD_ENQ, 32'sh5555_5555);
      send_beat(fts_pkg::CMD_ENQ, 32'shaaaa_aaaa);
      send_beat(fts_pkg::CMD_DEQ, 32'sh0000_0001);
      send_beat(fts_pkg::CMD_DEQ, '0);
      send_beat(fts_pkg::CMD_DEQ, 32'shffff_fffe);
      // push while outbound still holds entries
      send_beat(fts_pkg::CMD_ENQ, 32'sh1234_5678);
      send_beat(fts_pkg::CMD_DEQ, '0);
      send_beat(fts_pkg::CMD_DEQ, '0);
      send_beat(fts_pkg::CMD_DEQ, '0);
      send_beat(fts_pkg::CMD_DEQ, '0);
      send_beat(fts_pkg::CMD_DEQ, 32'sh7fff_ffff);
      send_beat(fts_pkg::CMD_DEQ, 32'sh8000_0000);

      fill_and_drain();
      run_mixed_traffic(200);

      send_idle_pct = 74;
      take_idle_pct = 33;
      phase         = 2;
      run_mixed_traffic(400);

      send_idle_pct = 0;
      take_idle_pct = 0;
      phase         = 3;
      run_mixed_traffic(400);
      req_valid <= 1'b0;

      do @(negedge clock); while (results_owed != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
